### sv/dcd_pkg.sv
// Package for the double clap detector: window size, field widths,
// configuration register indexes and shared types. No dependencies.
`default_nettype none
package dcd_pkg;

	localparam int WINDOW_SAMPLES = 16;
	localparam int AMP_W = 12;
	localparam int TIME_W = 32;
	localparam int MARGIN_W = 12;
	localparam int WIN_MS_W = 16;
	localparam int SLOT_W = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
	localparam int SUM_W = $clog2(WINDOW_SAMPLES * ((1 << AMP_W) - 1) + 1);

	localparam int IN_DATA_W = 48;
	localparam int OUT_DATA_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE_MARGIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLAP_WINDOW_MS = 1'd1;

	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 12'd100;
	localparam logic [WIN_MS_W-1:0] WIN_MS_RESET = 16'd500;

	typedef struct packed {
		logic [MARGIN_W-1:0] amplitude_margin;
		logic [WIN_MS_W-1:0] clap_window_ms;
	} cfg_t;

	typedef struct packed {
		logic [AMP_W-1:0] baseline;
		logic peak;
		logic double_clap;
	} result_t;

endpackage
`default_nettype wire

### sv/dcd_ring.sv
// Sample ring with running sum and baseline mean.
// Depends on dcd_pkg.
`default_nettype none
module dcd_ring
	import dcd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire logic [AMP_W-1:0] amplitude,
	output logic [AMP_W-1:0] baseline
);

	logic [AMP_W-1:0] ring_q [WINDOW_SAMPLES];
	logic [SLOT_W-1:0] slot_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_next;
	logic [SUM_W-1:0] mean;

	assign sum_next = sum_q - SUM_W'(ring_q[slot_q]) + SUM_W'(amplitude);
	assign mean = sum_next / SUM_W'(WINDOW_SAMPLES);
	assign baseline = mean[AMP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_SAMPLES; i++) begin
				ring_q[i] <= '0;
			end
			slot_q <= '0;
			sum_q <= '0;
		end else if (wr_en) begin
			ring_q[slot_q] <= amplitude;
			sum_q <= sum_next;
			if (slot_q == SLOT_W'(WINDOW_SAMPLES - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### sv/dcd_peak.sv
// Peak test against baseline plus margin and the two-peak clap tracker.
// Depends on dcd_pkg.
`default_nettype none
module dcd_peak
	import dcd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire cfg_t cfg,
	input  wire logic [AMP_W-1:0] amplitude,
	input  wire logic [TIME_W-1:0] time_ms,
	input  wire logic [AMP_W-1:0] baseline,
	output logic peak,
	output logic double_clap
);

	logic [TIME_W-1:0] last_peak_q;
	logic count_q;
	logic [TIME_W-1:0] gap;
	logic restart;

	assign peak = {1'b0, amplitude} > ({1'b0, baseline} + {1'b0, cfg.amplitude_margin});
	assign gap = time_ms - last_peak_q;
	assign restart = gap > TIME_W'(cfg.clap_window_ms);
	assign double_clap = peak && count_q && !restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_peak_q <= '0;
			count_q <= 1'b0;
		end else if (en && peak) begin
			last_peak_q <= time_ms;
			count_q <= !(count_q && !restart);
		end
	end

endmodule
`default_nettype wire

### sv/double_clap_detector_unit.sv
// Top level of the double clap detector: input register, configuration
// registers, output register. Depends on dcd_pkg, dcd_ring and dcd_peak.
//
// Channel   Dir  Fields (lowest bit up)
// s_axis    in   amplitude[11:0], time_ms[43:12], zero fill to 48 bits
// m_axis    out  double_clap[0], peak[1], baseline[13:2], zero fill to 16 bits
// cfg       in   cfg_wen, cfg_index, cfg_wdata
//
// One result beat for every input beat, at one beat per cycle while m_tready
// holds. Each beat passes the input register, then ring and peak logic into
// the output register. Stalls on the output hold both registers and drop
// s_tready only when both are full. Reset clears the ring, the sum, the
// clap tracker and sets the configuration to its defaults.
`default_nettype none
module double_clap_detector_unit
	import dcd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,    // amplitude, time_ms
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,       // double_clap, peak, baseline
	input  wire logic cfg_wen,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	logic valid_s1;
	logic [AMP_W-1:0] amp_s1;
	logic [TIME_W-1:0] time_s1;
	logic valid_s2;
	result_t res_s2;
	logic advance;
	logic step;
	logic [AMP_W-1:0] baseline;
	logic peak;
	logic double_clap;

	assign advance = !valid_s2 || m_tready;
	assign step = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amplitude_margin <= MARGIN_RESET;
			cfg_q.clap_window_ms <= WIN_MS_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_AMPLITUDE_MARGIN: cfg_q.amplitude_margin <= cfg_wdata[MARGIN_W-1:0];
				REG_CLAP_WINDOW_MS: cfg_q.clap_window_ms <= cfg_wdata[WIN_MS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			amp_s1 <= s_tdata[AMP_W-1:0];
			time_s1 <= s_tdata[AMP_W+TIME_W-1:AMP_W];
		end
	end

	dcd_ring u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (step),
		.amplitude (amp_s1),
		.baseline  (baseline)
	);

	dcd_peak u_peak (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (step),
		.cfg         (cfg_q),
		.amplitude   (amp_s1),
		.time_ms     (time_s1),
		.baseline    (baseline),
		.peak        (peak),
		.double_clap (double_clap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2.baseline <= baseline;
			res_s2.peak <= peak;
			res_s2.double_clap <= double_clap;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {{(OUT_DATA_W - AMP_W - 2){1'b0}}, res_s2};

endmodule
`default_nettype wire

### bench/dcd_clap_check.sv
// Checker for the double clap detector: mirrors the sample history and the clap
// tracker, predicts one verdict per input beat and compares each output beat.
// Depends on dcd_pkg.
`timescale 1ns / 1ps
module dcd_clap_check
	import dcd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	input  wire logic s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,
	input  wire logic m_tvalid,
	input  wire logic m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	input  wire logic cfg_wen,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output int fail_count,
	output int due_count
);

	logic [AMP_W-1:0] amp_hist [WINDOW_SAMPLES];
	logic [SLOT_W-1:0] hist_slot;
	logic [SUM_W-1:0] hist_sum;
	logic [TIME_W-1:0] last_peak_at;
	logic clap_armed;
	cfg_t thresholds;
	result_t verdicts_due [$];
	result_t want;
	result_t got;
	int errs;

	function automatic result_t judge_sample(input logic [AMP_W-1:0] amp,
			input logic [TIME_W-1:0] now);
		logic [AMP_W-1:0] base;
		logic [AMP_W:0] level;
		logic [AMP_W:0] bar;
		result_t r;
		hist_sum = hist_sum - SUM_W'(amp_hist[hist_slot]) + SUM_W'(amp);
		amp_hist[hist_slot] = amp;
		hist_slot = (hist_slot == SLOT_W'(WINDOW_SAMPLES - 1)) ? '0 : hist_slot + 1'b1;
		base = AMP_W'(hist_sum / WINDOW_SAMPLES);
		level = {1'b0, amp};
		bar = {1'b0, base} + {1'b0, thresholds.amplitude_margin};
		r.baseline = base;
		r.peak = 1'b0;
		r.double_clap = 1'b0;
		if (level > bar) begin
			r.peak = 1'b1;
			if (now - last_peak_at > TIME_W'(thresholds.clap_window_ms))
				clap_armed = 1'b0;
			last_peak_at = now;
			r.double_clap = clap_armed;
			clap_armed = !clap_armed;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_SAMPLES; i++)
				amp_hist[i] = '0;
			hist_slot = '0;
			hist_sum = '0;
			last_peak_at = '0;
			clap_armed = 1'b0;
			thresholds.amplitude_margin = MARGIN_RESET;
			thresholds.clap_window_ms = WIN_MS_RESET;
			verdicts_due.delete();
			errs = 0;
			fail_count <= 0;
			due_count <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
				REG_AMPLITUDE_MARGIN: thresholds.amplitude_margin = cfg_wdata[MARGIN_W-1:0];
				REG_CLAP_WINDOW_MS: thresholds.clap_window_ms = cfg_wdata[WIN_MS_W-1:0];
				default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				verdicts_due.push_back(judge_sample(s_tdata[AMP_W-1:0],
					s_tdata[AMP_W +: TIME_W]));
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[$bits(result_t)-1:0]);
				if (verdicts_due.size() == 0) begin
					$display("%0t: unexpected beat, expected none, got 0x%0h", $time, m_tdata);
					errs++;
				end else begin
					want = verdicts_due.pop_front();
					if (got.double_clap !== want.double_clap) begin
						$display("%0t: double_clap expected %0d, got %0d", $time,
							want.double_clap, got.double_clap);
						errs++;
					end
					if (got.peak !== want.peak) begin
						$display("%0t: peak expected %0d, got %0d", $time, want.peak, got.peak);
						errs++;
					end
					if (got.baseline !== want.baseline) begin
						$display("%0t: baseline expected %0d, got %0d", $time,
							want.baseline, got.baseline);
						errs++;
					end
					if (m_tdata[OUT_DATA_W-1:$bits(result_t)] !== '0) begin
						$display("%0t: fill bits expected 0, got 0x%0h", $time,
							m_tdata[OUT_DATA_W-1:$bits(result_t)]);
						errs++;
					end
				end
			end
			fail_count <= errs;
			due_count <= verdicts_due.size();
		end
	end

endmodule

### bench/tb_top.sv
// Top of the double clap detector bench: clock, reset, sample and threshold
// stimulus, output back-pressure and the verdict. Depends on dcd_pkg,
// double_clap_detector_unit and dcd_clap_check.
`timescale 1ns / 1ps
module tb_top;
	import dcd_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES = 90;
	localparam int PHASE_BEATS = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int fail_count;
	int due_count;
	int cycle_count = 0;
	int samples_sent = 0;
	int hold_asked = 0;
	int hold_served = 0;
	int hold_left = 0;
	bit steady = 1'b0;
	logic [TIME_W-1:0] now_ms = '0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	double_clap_detector_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	dcd_clap_check u_clap_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.due_count(due_count)
	);

	// A requested hold keeps the output stalled long enough for the block to fill up.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_served) begin
			hold_served <= hold_asked;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= 37);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic put_sample(input logic [AMP_W-1:0] amp, input logic [TIME_W-1:0] ts);
		while (!steady && $urandom_range(99) < 37) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W - AMP_W - TIME_W){1'b0}}, ts, amp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		samples_sent++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (due_count != 0)
			@(posedge clk);
	endtask

	task automatic set_thresholds(input logic [MARGIN_W-1:0] margin,
			input logic [WIN_MS_W-1:0] win);
		cfg_wen <= 1'b1;
		cfg_index <= REG_AMPLITUDE_MARGIN;
		cfg_wdata <= CFG_DATA_W'(margin);
		@(posedge clk);
		cfg_index <= REG_CLAP_WINDOW_MS;
		cfg_wdata <= CFG_DATA_W'(win);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Quiet background, a clap, up to three samples, then a second clap at any gap.
	task automatic clap_episode(input logic [WIN_MS_W-1:0] win);
		logic [TIME_W-1:0] dt;
		int unsigned quiet;
		int unsigned between;
		quiet = $urandom_range(0, 12);
		repeat (quiet) begin
			now_ms += $urandom_range(1, 40);
			put_sample(AMP_W'($urandom_range(0, 300)), now_ms);
		end
		now_ms += $urandom_range(1, 40);
		put_sample(AMP_W'($urandom_range(1200, 4095)), now_ms);
		case ($urandom_range(0, 4))
		0: dt = TIME_W'(win);
		1: dt = TIME_W'(win) + 1;
		2: dt = $urandom_range(0, TIME_W'(win));
		3: dt = TIME_W'(win) + $urandom_range(2, 400);
		default: dt = $urandom();
		endcase
		between = $urandom_range(0, 3);
		repeat (between)
			put_sample(AMP_W'($urandom_range(0, 300)), now_ms + $urandom_range(0, dt));
		now_ms += dt;
		put_sample(AMP_W'($urandom_range(1200, 4095)), now_ms);
	endtask

	initial begin
		logic [MARGIN_W-1:0] margin;
		logic [WIN_MS_W-1:0] win;
		int goal;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset thresholds: margin 100, window 500.
		put_sample(12'd0, 32'd0);
		put_sample(12'hFFF, 32'd0);
		put_sample(12'hFFF, 32'd500);
		put_sample(12'hFFF, 32'd1000);
		put_sample(12'hFFF, 32'd1501);
		put_sample(12'hFFF, 32'hFFFF_FFF0);
		put_sample(12'hFFF, 32'h0000_0010);
		put_sample(12'hFFF, 32'hFFFF_FFFF);
		put_sample(12'hFFF, 32'hFFFF_FF00);
		put_sample(12'd1, 32'd7);
		settle();
		set_thresholds(12'd0, 16'd0);
		put_sample(12'd0, 32'd100);
		put_sample(12'd4000, 32'd200);
		put_sample(12'd4000, 32'd200);
		put_sample(12'd4000, 32'd201);
		settle();
		set_thresholds(12'hFFF, 16'hFFFF);
		put_sample(12'hFFF, 32'd300);
		put_sample(12'd2048, 32'h5555_AAAA);
		settle();
		set_thresholds(12'd0, 16'hFFFF);
		put_sample(12'hFFF, 32'd65737);
		put_sample(12'hFFF, 32'd131272);
		put_sample(12'hFFF, 32'd131300);
		put_sample(12'hAAA, 32'hAAAA_5555);
		settle();

		for (int phase = 0; phase < 10; phase++) begin
			margin = ($urandom_range(0, 7) == 0) ? MARGIN_W'($urandom_range(0, 4095)) :
				MARGIN_W'($urandom_range(0, 700));
			case ($urandom_range(0, 9))
			0: win = 16'hFFFF;
			1: win = 16'd0;
			default: win = WIN_MS_W'($urandom_range(0, 3000));
			endcase
			set_thresholds(margin, win);
			now_ms = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20000) :
				$urandom();
			if (phase == 3)
				steady <= 1'b1;
			if (phase == 5 || phase == 8)
				hold_asked <= hold_asked + 1;
			goal = samples_sent + PHASE_BEATS;
			while (samples_sent < goal) begin
				if ($urandom_range(99) < 80) begin
					clap_episode(win);
				end else begin
					put_sample(AMP_W'($urandom_range(0, 4095)), $urandom());
				end
			end
			settle();
			steady <= 1'b0;
		end

		repeat (6) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

### sim.f
sv/dcd_pkg.sv
sv/dcd_ring.sv
sv/dcd_peak.sv
sv/double_clap_detector_unit.sv
bench/dcd_clap_check.sv
bench/tb_top.sv
